### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion shorthands, sampled on clk, off in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

### hdl/mae_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mae_pkg
// types, opcode constants and operation classes of the alu execute block
// ---------------------------------------------------------------------------
package mae_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int OUT_DEPTH   = 2;

  // primary opcodes
  localparam logic [5:0] OPC_RTYPE = 6'h00;
  localparam logic [5:0] OPC_BLTZ  = 6'h01;
  localparam logic [5:0] OPC_J     = 6'h02;
  localparam logic [5:0] OPC_JAL   = 6'h03;
  localparam logic [5:0] OPC_BEQ   = 6'h04;
  localparam logic [5:0] OPC_BNE   = 6'h05;
  localparam logic [5:0] OPC_BLEZ  = 6'h06;
  localparam logic [5:0] OPC_BGTZ  = 6'h07;
  localparam logic [5:0] OPC_ADDI  = 6'h08;
  localparam logic [5:0] OPC_ADDIU = 6'h09;
  localparam logic [5:0] OPC_SLTI  = 6'h0A;
  localparam logic [5:0] OPC_ORI   = 6'h0D;
  localparam logic [5:0] OPC_XORI  = 6'h0E;
  localparam logic [5:0] OPC_LUI   = 6'h0F;
  localparam logic [5:0] OPC_LB    = 6'h20;
  localparam logic [5:0] OPC_LH    = 6'h21;
  localparam logic [5:0] OPC_LW    = 6'h23;
  localparam logic [5:0] OPC_SB    = 6'h28;
  localparam logic [5:0] OPC_SH    = 6'h29;
  localparam logic [5:0] OPC_SW    = 6'h2B;

  // function codes
  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_JR    = 6'h08;
  localparam logic [5:0] FN_JALR  = 6'h09;
  localparam logic [5:0] FN_SYSC  = 6'h0C;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MTHI  = 6'h11;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_MTLO  = 6'h13;
  localparam logic [5:0] FN_MULT  = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_DIV   = 6'h1A;
  localparam logic [5:0] FN_DIVU  = 6'h1B;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_SUBU  = 6'h23;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_NOR   = 6'h27;
  localparam logic [5:0] FN_SLT   = 6'h2A;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_IDLE    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_DIVZERO = 2'd3;

  typedef enum logic [3:0] {
    CLS_ADD, CLS_SUB, CLS_AND, CLS_OR, CLS_XOR, CLS_NOR, CLS_SLT,
    CLS_SLL, CLS_SRL, CLS_SRA, CLS_MUL, CLS_DIVS, CLS_DIVU, CLS_PASS, CLS_ZERO
  } op_cls_t;

  typedef struct packed {
    logic [5:0]  opcode;
    logic [5:0]  funct;
    logic [4:0]  shift_amount;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [15:0] immediate;
  } in_t;

  typedef struct packed {
    logic [31:0] alu_result;
    logic [31:0] store_data;
    logic [1:0]  status;
  } out_t;

  typedef struct packed {
    op_cls_t     cls;
    logic [31:0] a;
    logic [31:0] b;
    logic [4:0]  sh;
    logic [31:0] sd;
    logic [1:0]  status;
  } dec_t;

endpackage

### hdl/mae_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mae_fifo
// small register queue with count, used between decode and execute and
// on the result side
// ---------------------------------------------------------------------------
module mae_fifo #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

### hdl/mae_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mae_front
// instruction decode: classifies each beat, extends the immediate and
// settles status and store data ahead of execution
// ---------------------------------------------------------------------------
module mae_front (
  input  mae_pkg::in_t  in_data,
  output mae_pkg::dec_t dec
);
  import mae_pkg::*;

  logic [31:0] sext, zext;

  assign sext = {{16{in_data.immediate[15]}}, in_data.immediate};
  assign zext = {16'b0, in_data.immediate};

  always_comb begin
    dec.cls    = CLS_ZERO;
    dec.a      = in_data.operand_a;
    dec.b      = in_data.operand_b;
    dec.sh     = in_data.shift_amount;
    dec.sd     = '0;
    dec.status = ST_OK;
    if (in_data.opcode == OPC_RTYPE) begin
      unique case (in_data.funct)
        FN_ADD, FN_ADDU:   dec.cls = CLS_ADD;
        FN_SUB, FN_SUBU:   dec.cls = CLS_SUB;
        FN_AND:            dec.cls = CLS_AND;
        FN_OR:             dec.cls = CLS_OR;
        FN_XOR:            dec.cls = CLS_XOR;
        FN_NOR:            dec.cls = CLS_NOR;
        FN_SLT:            dec.cls = CLS_SLT;
        FN_SLL:            dec.cls = CLS_SLL;
        FN_SRL:            dec.cls = CLS_SRL;
        FN_SRA:            dec.cls = CLS_SRA;
        FN_MULT, FN_MULTU: dec.cls = CLS_MUL;
        FN_MTHI, FN_MTLO:  dec.cls = CLS_PASS;
        FN_DIV, FN_DIVU: begin
          if (in_data.operand_b == '0) begin
            dec.status = ST_DIVZERO;
          end else begin
            dec.cls = (in_data.funct == FN_DIV) ? CLS_DIVS : CLS_DIVU;
          end
        end
        FN_JR, FN_JALR, FN_SYSC, FN_MFHI, FN_MFLO: dec.status = ST_IDLE;
        default:           dec.status = ST_INVALID;
      endcase
    end else begin
      unique case (in_data.opcode)
        OPC_ADDI, OPC_ADDIU: begin
          dec.cls = CLS_ADD;
          dec.b   = sext;
        end
        OPC_ORI: begin
          dec.cls = CLS_OR;
          dec.b   = zext;
        end
        OPC_XORI: begin
          dec.cls = CLS_XOR;
          dec.b   = zext;
        end
        OPC_SLTI: begin
          dec.cls = CLS_SLT;
          dec.b   = sext;
        end
        OPC_LUI: begin
          dec.cls = CLS_PASS;
          dec.a   = {in_data.immediate, 16'b0};
        end
        OPC_LB, OPC_LH, OPC_LW, OPC_SB, OPC_SH, OPC_SW: begin
          dec.cls = CLS_ADD;
          dec.b   = sext;
          dec.sd  = in_data.operand_b;
        end
        OPC_BLTZ, OPC_J, OPC_JAL, OPC_BEQ, OPC_BNE, OPC_BLEZ, OPC_BGTZ:
          dec.status = ST_IDLE;
        default: dec.status = ST_INVALID;
      endcase
    end
  end

endmodule

### hdl/mae_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mae_back
// execute: combinational alu, shifter and multiplier, plus a radix-2
// restoring divider that holds issue while it iterates
// ---------------------------------------------------------------------------
module mae_back (
  input  logic          clk,
  input  logic          rst_n,
  input  mae_pkg::dec_t q_data,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          o_push,
  output mae_pkg::out_t o_data,
  input  logic          o_room
);
  import mae_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    DV_IDLE = 3'b001,
    DV_RUN  = 3'b010,
    DV_DONE = 3'b100
  } dv_state_t;

  dv_state_t   st_r, st_nxt;
  logic [31:0] rem_r, rem_nxt, quo_r, quo_nxt, dvs_r, dvs_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic [32:0] rem_sh, diff;
  logic [31:0] res, mag_a, mag_b, quo_step;
  logic        is_div;

  assign is_div = (q_data.cls == CLS_DIVS) || (q_data.cls == CLS_DIVU);
  assign q_pop  = !q_empty && (st_r == DV_IDLE) && o_room;

  always_comb begin
    case (q_data.cls)
      CLS_ADD:  res = q_data.a + q_data.b;
      CLS_SUB:  res = q_data.a - q_data.b;
      CLS_AND:  res = q_data.a & q_data.b;
      CLS_OR:   res = q_data.a | q_data.b;
      CLS_XOR:  res = q_data.a ^ q_data.b;
      CLS_NOR:  res = ~(q_data.a | q_data.b);
      CLS_SLT:  res = {31'b0, $signed(q_data.a) < $signed(q_data.b)};
      CLS_SLL:  res = q_data.b << q_data.sh;
      CLS_SRL:  res = q_data.b >> q_data.sh;
      CLS_SRA:  res = $unsigned($signed(q_data.b) >>> q_data.sh);
      CLS_MUL:  res = q_data.a * q_data.b;
      CLS_PASS: res = q_data.a;
      default:  res = '0;
    endcase
  end

  assign mag_a    = (q_data.cls == CLS_DIVS && q_data.a[31]) ? -q_data.a : q_data.a;
  assign mag_b    = (q_data.cls == CLS_DIVS && q_data.b[31]) ? -q_data.b : q_data.b;
  assign rem_sh   = {rem_r, quo_r[31]};
  assign diff     = rem_sh - {1'b0, dvs_r};
  assign quo_step = {quo_r[30:0], ~diff[32]};

  always_comb begin
    st_nxt  = st_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    neg_nxt = neg_r;
    unique case (st_r)
      DV_IDLE: begin
        if (q_pop && is_div) begin
          st_nxt  = DV_RUN;
          rem_nxt = '0;
          quo_nxt = mag_a;
          dvs_nxt = mag_b;
          cnt_nxt = '0;
          neg_nxt = (q_data.cls == CLS_DIVS) && (q_data.a[31] ^ q_data.b[31]);
        end
      end
      DV_RUN: begin
        rem_nxt = diff[32] ? rem_sh[31:0] : diff[31:0];
        quo_nxt = quo_step;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'd31) begin
          st_nxt  = DV_DONE;
          quo_nxt = neg_r ? -quo_step : quo_step;
        end
      end
      DV_DONE: begin
        if (o_room) begin
          st_nxt = DV_IDLE;
        end
      end
      default: st_nxt = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= DV_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
  end

  always_comb begin
    if (st_r == DV_DONE) begin
      o_push = o_room;
      o_data = '{alu_result: quo_r, store_data: '0, status: ST_OK};
    end else begin
      o_push = q_pop && !is_div;
      o_data = '{alu_result: res, store_data: q_data.sd, status: q_data.status};
    end
  end

  `ASSERT_IMPLY(a_no_issue_busy, st_r != DV_IDLE, !q_pop, "issue while divider busy")
  `ASSERT_NEXT(a_div_finish, st_r == DV_RUN && cnt_r == 5'd31, st_r == DV_DONE, "divider overran")
  `ASSERT_IMPLY(a_push_room, o_push, o_room, "result beat pushed without room")

endmodule

### hdl/mips_alu_execute.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mips_alu_execute
// mips32 execute stage alu: decode, issue queue, execute, result queue
// ---------------------------------------------------------------------------
// One beat in gives one result beat out, in order. Every instruction except
// div and divu with a nonzero divisor passes straight through the execute
// unit, so a steady stream runs at one beat per cycle while the result queue
// has room. An accepted beat waits in the issue queue, and its result in the
// result queue, before it can be popped. div and divu with a nonzero divisor
// go through a one-bit-per-cycle restoring divider. Each one holds the
// execute unit through issue, 32 iterations and the result push, and the
// decode queue backs up meanwhile. Both queues are QUEUE_DEPTH / OUT_DEPTH
// entries deep.
module mips_alu_execute #(
  parameter int QUEUE_DEPTH = mae_pkg::QUEUE_DEPTH,
  parameter int OUT_DEPTH   = mae_pkg::OUT_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  mae_pkg::in_t  in_data,
  output logic          in_full,
  output logic          out_empty,
  input  logic          out_pop,
  output mae_pkg::out_t out_data
);
  import mae_pkg::*;

  dec_t dec, q_data;
  out_t o_data;
  logic q_empty, q_pop, o_push, o_full, o_room;

  mae_front u_front (
    .in_data (in_data),
    .dec     (dec)
  );

  mae_fifo #(.DEPTH(QUEUE_DEPTH), .WIDTH($bits(dec_t))) u_issue_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (dec),
    .full  (in_full),
    .pop   (q_pop),
    .rdata (q_data),
    .empty (q_empty)
  );

  mae_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_data  (q_data),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .o_push  (o_push),
    .o_data  (o_data),
    .o_room  (o_room)
  );

  assign o_room = !o_full;

  mae_fifo #(.DEPTH(OUT_DEPTH), .WIDTH($bits(out_t))) u_result_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (o_push),
    .wdata (o_data),
    .full  (o_full),
    .pop   (out_pop),
    .rdata (out_data),
    .empty (out_empty)
  );

endmodule
